// ===== sv/rlp_pkg.sv =====
// ----------------------------------------------------------------------------
// rlp_pkg: shared types and constants for the integer literal parser
// Character codes, parser phase codes, the transaction type between the
// input stage and the parse core, and the digit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rlp_pkg;

  // Width of digit values and radix values
  localparam int unsigned DIGIT_W = 7;
  localparam int unsigned VALUE_W = 64;

  // Parser phases
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_PREFIX   = 2'd1;
  localparam logic [1:0] PH_BIN_WAIT = 2'd2;
  localparam logic [1:0] PH_DIGITS   = 2'd3;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_LO_B  = 8'h62;

  // Digit values and radix constants
  localparam logic [DIGIT_W-1:0] NO_DIGIT    = 7'd64;
  localparam logic [DIGIT_W-1:0] DIG_AT      = 7'd62;
  localparam logic [DIGIT_W-1:0] DIG_UNDER   = 7'd63;
  localparam logic [DIGIT_W-1:0] RADIX_BIN   = 7'd2;
  localparam logic [DIGIT_W-1:0] RADIX_OCT   = 7'd8;
  localparam logic [DIGIT_W-1:0] RADIX_DEC   = 7'd10;
  localparam logic [DIGIT_W-1:0] RADIX_HEX   = 7'd16;
  localparam logic [DIGIT_W-1:0] RADIX_CASE  = 7'd36;
  localparam logic [VALUE_W-1:0] BASE_LIMIT  = 64'd64;
  localparam logic [VALUE_W-1:0] BASE_MIN    = 64'd2;

  // One input transaction
  typedef struct packed {
    logic [7:0] character;
    logic       first;
  } item_t;

  // Digit value of a character under a radix, NO_DIGIT if none
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c,
                                                  input logic [DIGIT_W-1:0] radix);
    logic [7:0] d;
    d = 8'(NO_DIGIT);
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d = c - CH_ZERO;
    end else if (c inside {[CH_UP_A:CH_UP_Z]}) begin
      d = (radix > RADIX_CASE) ? (c - CH_UP_A + 8'd36) : (c - CH_UP_A + 8'd10);
    end else if (c inside {[CH_LO_A:CH_LO_Z]}) begin
      d = c - CH_LO_A + 8'd10;
    end else if (c == CH_AT) begin
      d = 8'(DIG_AT);
    end else if (c == CH_UNDER) begin
      d = 8'(DIG_UNDER);
    end
    return d[DIGIT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/radix_integer_literal_parser.sv =====
// ----------------------------------------------------------------------------
// radix_integer_literal_parser: streaming integer literal parser
// Reads one character per transaction and returns value, length and radix
// of each literal (hex, binary, base#digits, octal, decimal).
// ----------------------------------------------------------------------------
// Takes one character transaction per clock cycle, with in_first marking the
// start of a literal, and returns one result transaction when a literal ends
// (on the character that ends it, which itself is not counted). An accepted
// character goes through the input register, then through the parse logic
// into the result register. The rate is one character per cycle, set by the
// combinational 64-by-7 multiply-accumulate of the radix digits; while the
// result register holds an untaken result, the parse core holds its
// character and input stalls once the input register is full. out_consumed
// saturates at COUNT_MAX and carries its low eight bits.
`default_nettype none

module radix_integer_literal_parser #(
  parameter int unsigned COUNT_MAX = 255
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_character,
  input  wire logic          in_first,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic signed [63:0] out_value,
  output logic [7:0]         out_consumed,
  output logic [6:0]         out_radix
);

  localparam int unsigned CW = $clog2(COUNT_MAX + 1);

  logic           item_valid;
  logic           item_take;
  rlp_pkg::item_t item;

  // Input register
  rlp_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .in_first     (in_first),
    .item_valid   (item_valid),
    .item_take    (item_take),
    .item         (item)
  );

  // Parse logic and result register
  rlp_parse_core #(
    .COUNT_MAX (COUNT_MAX),
    .CW        (CW)
  ) u_parse_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_take    (item_take),
    .item         (item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_consumed (out_consumed),
    .out_radix    (out_radix)
  );

endmodule

`default_nettype wire

// ===== sv/rlp_in_stage.sv =====
// ----------------------------------------------------------------------------
// rlp_in_stage: input register of the literal parser
// Captures one character transaction and holds it until the parse core
// takes it; refills in the same cycle the held transaction leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module rlp_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_character,
  input  wire logic          in_first,
  output logic               item_valid,
  input  wire logic          item_take,
  output rlp_pkg::item_t     item
);

  logic           vld_r;
  logic           vld_nxt;
  rlp_pkg::item_t item_r;

  // Accept when empty or when the held transaction leaves this cycle
  assign in_ready = !vld_r || item_take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (item_take) begin
      vld_nxt = 1'b0;
    end
  end

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.character <= in_character;
      item_r.first     <= in_first;
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== sv/rlp_parse_core.sv =====
// ----------------------------------------------------------------------------
// rlp_parse_core: literal state machine, accumulators and result register
// Advances the parse state by one character per cycle while no untaken result
// holds it, and loads the result register when a literal ends.
// ----------------------------------------------------------------------------
`default_nettype none

module rlp_parse_core #(
  parameter int unsigned COUNT_MAX = 255,
  parameter int unsigned CW        = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 item_valid,
  output logic                      item_take,
  input  wire rlp_pkg::item_t       item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [63:0]        out_value,
  output logic [7:0]                out_consumed,
  output logic [6:0]                out_radix
);

  localparam logic [CW-1:0] CNT_MAX = CW'(COUNT_MAX);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);
  localparam logic [CW-1:0] CNT_TWO = CW'(2);
  localparam logic [CW-1:0] CNT_THR = CW'(3);

  // Parse state
  logic [1:0]    phase_r, phase_nxt;
  logic          lz_r, lz_nxt;
  logic [63:0]   dec_r, dec_nxt;
  logic          bol_r, bol_nxt;
  logic [63:0]   oct_r, oct_nxt;
  logic          octh_r, octh_nxt;
  logic [CW-1:0] octc_r, octc_nxt;
  logic [6:0]    radix_r, radix_nxt;
  logic [63:0]   rsum_r, rsum_nxt;
  logic [CW-1:0] cc_r, cc_nxt;

  // Result register
  logic          out_vld_r, out_vld_nxt;
  logic [63:0]   out_value_r;
  logic [CW-1:0] out_cnt_r;
  logic [6:0]    out_radix_r;

  // Result of this transaction
  logic          emit;
  logic [63:0]   emit_value;
  logic [CW-1:0] emit_cnt;
  logic [6:0]    emit_radix;

  // Prefix digit step
  logic [7:0]    c;
  logic          c_dec;
  logic [3:0]    pd;
  logic [63:0]   src_dec, src_oct;
  logic          src_bol, src_octh;
  logic [CW-1:0] src_octc, src_cc;
  logic [63:0]   dec_step, oct_step;
  logic          bol_step, octh_step;
  logic [CW-1:0] octc_step, cc_step;

  // Radix digit step
  logic [6:0]    dig;
  logic [63:0]   rprod;
  logic [63:0]   rsum_step;
  logic [CW-1:0] cc_inc;
  logic [CW+7:0] cnt_ext;

  assign item_take = item_valid && (!out_vld_r || out_ready);
  assign c         = item.character;
  assign c_dec     = c inside {[rlp_pkg::CH_ZERO:rlp_pkg::CH_NINE]};
  assign pd        = 4'(c - rlp_pkg::CH_ZERO);

  // A first character starts from the reset state
  assign src_dec  = item.first ? 64'd0 : dec_r;
  assign src_oct  = item.first ? 64'd0 : oct_r;
  assign src_bol  = item.first ? 1'b0 : bol_r;
  assign src_octh = item.first ? 1'b0 : octh_r;
  assign src_octc = item.first ? '0 : octc_r;
  assign src_cc   = item.first ? '0 : cc_r;

  // Advance decimal and octal sums by one decimal digit
  always_comb begin
    dec_step  = {src_dec[60:0], 3'b000} + {src_dec[62:0], 1'b0} + {60'd0, pd};
    bol_step  = src_bol || (dec_step > rlp_pkg::BASE_LIMIT);
    oct_step  = src_oct;
    octh_step = src_octh;
    octc_step = src_octc;
    if (!src_octh) begin
      if (pd < 4'd8) begin
        oct_step  = {src_oct[60:0], pd[2:0]};
        octc_step = (src_octc < CNT_MAX) ? src_octc + CNT_ONE : src_octc;
      end else begin
        octh_step = 1'b1;
      end
    end
    cc_step = (src_cc < CNT_MAX) ? src_cc + CNT_ONE : src_cc;
  end

  // Multiply-accumulate for the radix digits, wrapping at 64 bits
  assign dig       = rlp_pkg::digit_of(c, radix_r);
  assign rprod     = rsum_r * {57'd0, radix_r};
  assign rsum_step = rprod + {57'd0, dig};
  assign cc_inc    = (cc_r < CNT_MAX) ? cc_r + CNT_ONE : cc_r;

  // Next parse state and result
  always_comb begin
    phase_nxt  = phase_r;
    lz_nxt     = lz_r;
    dec_nxt    = dec_r;
    bol_nxt    = bol_r;
    oct_nxt    = oct_r;
    octh_nxt   = octh_r;
    octc_nxt   = octc_r;
    radix_nxt  = radix_r;
    rsum_nxt   = rsum_r;
    cc_nxt     = cc_r;
    emit       = 1'b0;
    emit_value = dec_r;
    emit_cnt   = cc_r;
    emit_radix = rlp_pkg::RADIX_DEC;
    if (item.first) begin
      // Restart; drop any unfinished literal
      phase_nxt = rlp_pkg::PH_IDLE;
      lz_nxt    = 1'b0;
      dec_nxt   = '0;
      bol_nxt   = 1'b0;
      oct_nxt   = '0;
      octh_nxt  = 1'b0;
      octc_nxt  = '0;
      radix_nxt = rlp_pkg::RADIX_DEC;
      rsum_nxt  = '0;
      cc_nxt    = '0;
      if (c_dec) begin
        lz_nxt    = (c == rlp_pkg::CH_ZERO);
        dec_nxt   = dec_step;
        bol_nxt   = bol_step;
        oct_nxt   = oct_step;
        octh_nxt  = octh_step;
        octc_nxt  = octc_step;
        cc_nxt    = cc_step;
        phase_nxt = rlp_pkg::PH_PREFIX;
      end
    end else begin
      case (phase_r)
        rlp_pkg::PH_PREFIX: begin
          if (lz_r && cc_r == CNT_ONE &&
              (c == rlp_pkg::CH_LO_X || c == rlp_pkg::CH_UP_X)) begin
            radix_nxt = rlp_pkg::RADIX_HEX;
            rsum_nxt  = '0;
            cc_nxt    = CNT_TWO;
            phase_nxt = rlp_pkg::PH_DIGITS;
          end else if (lz_r && cc_r == CNT_ONE &&
                       (c == rlp_pkg::CH_LO_B || c == rlp_pkg::CH_UP_B)) begin
            phase_nxt = rlp_pkg::PH_BIN_WAIT;
          end else if (c_dec) begin
            dec_nxt  = dec_step;
            bol_nxt  = bol_step;
            oct_nxt  = oct_step;
            octh_nxt = octh_step;
            octc_nxt = octc_step;
            cc_nxt   = cc_step;
          end else if (c == rlp_pkg::CH_HASH && !bol_r && dec_r >= rlp_pkg::BASE_MIN &&
                       dec_r <= rlp_pkg::BASE_LIMIT) begin
            radix_nxt = dec_r[6:0];
            rsum_nxt  = '0;
            cc_nxt    = cc_inc;
            phase_nxt = rlp_pkg::PH_DIGITS;
          end else begin
            emit      = 1'b1;
            phase_nxt = rlp_pkg::PH_IDLE;
            if (lz_r && cc_r >= CNT_TWO) begin
              emit_value = oct_r;
              emit_cnt   = octc_r;
              emit_radix = rlp_pkg::RADIX_OCT;
            end
          end
        end
        rlp_pkg::PH_BIN_WAIT: begin
          if (c == rlp_pkg::CH_ZERO || c == rlp_pkg::CH_ONE) begin
            radix_nxt = rlp_pkg::RADIX_BIN;
            rsum_nxt  = {63'd0, c[0]};
            cc_nxt    = CNT_THR;
            phase_nxt = rlp_pkg::PH_DIGITS;
          end else begin
            emit       = 1'b1;
            emit_value = '0;
            emit_cnt   = CNT_ONE;
            phase_nxt  = rlp_pkg::PH_IDLE;
          end
        end
        rlp_pkg::PH_DIGITS: begin
          if (dig < radix_r) begin
            rsum_nxt = rsum_step;
            cc_nxt   = cc_inc;
          end else begin
            emit       = 1'b1;
            emit_value = rsum_r;
            emit_radix = radix_r;
            phase_nxt  = rlp_pkg::PH_IDLE;
          end
        end
        default: begin
          // Idle: ignore characters
        end
      endcase
    end
  end

  // Result register valid
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (item_take && emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= rlp_pkg::PH_IDLE;
      lz_r      <= 1'b0;
      bol_r     <= 1'b0;
      octh_r    <= 1'b0;
      octc_r    <= '0;
      radix_r   <= rlp_pkg::RADIX_DEC;
      cc_r      <= '0;
      dec_r     <= '0;
      oct_r     <= '0;
      rsum_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (item_take) begin
        phase_r <= phase_nxt;
        lz_r    <= lz_nxt;
        bol_r   <= bol_nxt;
        octh_r  <= octh_nxt;
        octc_r  <= octc_nxt;
        radix_r <= radix_nxt;
        cc_r    <= cc_nxt;
        dec_r   <= dec_nxt;
        oct_r   <= oct_nxt;
        rsum_r  <= rsum_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      out_value_r <= emit_value;
      out_cnt_r   <= emit_cnt;
      out_radix_r <= emit_radix;
    end
  end

  assign cnt_ext      = {8'd0, out_cnt_r};
  assign out_valid    = out_vld_r;
  assign out_value    = out_value_r;
  assign out_consumed = cnt_ext[7:0];
  assign out_radix    = out_radix_r;

endmodule

`default_nettype wire
